>>> src/pra_pkg.sv
package pra_pkg;

  localparam int KeyBits     = 64;
  localparam int ValueBits   = 32;
  localparam int CountBits   = 32;
  localparam int AvgFracBits = 16;
  localparam int SumBits     = 64;
  localparam int AvgBits     = 48;
  localparam int WorkBits    = SumBits + AvgFracBits;
  localparam int DivSteps    = WorkBits;
  localparam int StepBits    = $clog2(DivSteps + 1);
  localparam int QueueDepth  = 2;
  localparam int PtrBits     = $clog2(QueueDepth);

  typedef struct packed {
    logic [CountBits-1:0]        row_count;
    logic [CountBits-1:0]        value_count;
    logic signed [SumBits-1:0]   value_sum;
    logic signed [ValueBits-1:0] value_min;
    logic signed [ValueBits-1:0] value_max;
    logic                        no_values;
    logic                        new_partition;
  } pra_acc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } pra_state_t;

endpackage

>>> src/pra_if.sv
interface pra_in_if import pra_pkg::*;;
  logic        valid;
  logic        ready;
  logic [KeyBits-1:0] part_key;
  logic        part_key_null;
  logic signed [ValueBits-1:0] value;
  logic        value_null;
  modport source(output valid, part_key, part_key_null, value, value_null, input ready);
  modport sink(input valid, part_key, part_key_null, value, value_null, output ready);
endinterface

interface pra_out_if import pra_pkg::*;;
  logic        valid;
  logic        ready;
  logic [CountBits-1:0] row_count;
  logic [CountBits-1:0] value_count;
  logic signed [SumBits-1:0] value_sum;
  logic signed [AvgBits-1:0] value_avg;
  logic signed [ValueBits-1:0] value_min;
  logic signed [ValueBits-1:0] value_max;
  logic        no_values;
  logic        new_partition;
  modport source(output valid, row_count, value_count, value_sum, value_avg, value_min,
                 value_max, no_values, new_partition, input ready);
  modport sink(input valid, row_count, value_count, value_sum, value_avg, value_min,
               value_max, no_values, new_partition, output ready);
endinterface

>>> src/pra_front.sv
module pra_front import pra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_en,
  input  logic      cfg_partition_enable,
  pra_in_if.sink    in_ch,
  output logic      acc_valid,
  input  logic      acc_ready,
  output pra_acc_t  acc
);

  logic                        part_en_r;
  logic [KeyBits-1:0]          last_key_r;
  logic                        last_null_r;
  logic                        have_r;
  logic [CountBits-1:0]        rows_r;
  logic [CountBits-1:0]        vals_r;
  logic signed [SumBits-1:0]   sum_r;
  logic signed [ValueBits-1:0] min_r;
  logic signed [ValueBits-1:0] max_r;

  logic                        same;
  logic                        fire;
  logic [CountBits-1:0]        rows_b, vals_b, rows_nxt, vals_nxt;
  logic signed [SumBits-1:0]   sum_b, sum_nxt;
  logic signed [ValueBits-1:0] min_b, max_b, min_nxt, max_nxt;
  logic signed [ValueBits-1:0] v;

  assign in_ch.ready = acc_ready;
  assign acc_valid   = in_ch.valid;
  assign fire        = in_ch.valid && acc_ready;
  assign v           = in_ch.value;

  always_comb begin
    if (!have_r) begin
      same = 1'b0;
    end else if (!part_en_r) begin
      same = 1'b1;
    end else if (in_ch.part_key_null != last_null_r) begin
      same = 1'b0;
    end else begin
      same = in_ch.part_key_null || (in_ch.part_key == last_key_r);
    end
    rows_b = same ? rows_r : '0;
    vals_b = same ? vals_r : '0;
    sum_b  = same ? sum_r : '0;
    min_b  = same ? min_r : '0;
    max_b  = same ? max_r : '0;
    rows_nxt = (&rows_b) ? rows_b : rows_b + 1'b1;
    vals_nxt = vals_b;
    sum_nxt  = sum_b;
    min_nxt  = min_b;
    max_nxt  = max_b;
    if (!in_ch.value_null) begin
      if (vals_b == '0) begin
        min_nxt = v;
        max_nxt = v;
      end else begin
        if (v < min_b) min_nxt = v;
        if (v > max_b) max_nxt = v;
      end
      vals_nxt = (&vals_b) ? vals_b : vals_b + 1'b1;
      sum_nxt  = sum_b + SumBits'(v);
    end
    acc.row_count     = rows_nxt;
    acc.value_count   = vals_nxt;
    acc.no_values     = (vals_nxt == '0);
    acc.value_sum     = acc.no_values ? '0 : sum_nxt;
    acc.value_min     = acc.no_values ? '0 : min_nxt;
    acc.value_max     = acc.no_values ? '0 : max_nxt;
    acc.new_partition = !same;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_en_r   <= 1'b1;
      last_key_r  <= '0;
      last_null_r <= 1'b1;
      have_r      <= 1'b0;
      rows_r      <= '0;
      vals_r      <= '0;
      sum_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
    end else begin
      if (cfg_en) part_en_r <= cfg_partition_enable;
      if (fire) begin
        if (!same) begin
          have_r      <= 1'b1;
          last_key_r  <= in_ch.part_key_null ? '0 : in_ch.part_key;
          last_null_r <= in_ch.part_key_null;
        end
        rows_r <= rows_nxt;
        vals_r <= vals_nxt;
        sum_r  <= sum_nxt;
        min_r  <= min_nxt;
        max_r  <= max_nxt;
      end
    end
  end

endmodule

>>> src/pra_queue.sv
module pra_queue import pra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  pra_acc_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output pra_acc_t rd_data
);

  pra_acc_t           mem_r [QueueDepth];
  logic [PtrBits-1:0] wp_r, rp_r;
  logic [PtrBits:0]   cnt_r;
  logic               wr, rd;

  assign wr_ready = (cnt_r != (PtrBits+1)'(QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == PtrBits'(QueueDepth - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == PtrBits'(QueueDepth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrBits+1)'(wr) - (PtrBits+1)'(rd);
    end
  end

endmodule

>>> src/pra_back.sv
module pra_back import pra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  pra_acc_t q_data,
  pra_out_if.source out_ch
);

  pra_state_t            state_r, state_nxt;
  pra_acc_t              item_r;
  logic [WorkBits-1:0]   quo_r;
  logic [CountBits:0]    rem_r;
  logic [StepBits-1:0]   step_r;
  logic                  neg_r;
  logic signed [AvgBits-1:0] avg_r;

  logic [SumBits-1:0]    mag;
  logic [CountBits:0]    trial;
  logic                  take, load, fix;
  logic [AvgBits-1:0]    lim;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_DIV;
      ST_DIV:  if (step_r == StepBits'(DivSteps - 1)) state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready      = 1'b0;
    out_ch.valid = 1'b0;
    load         = 1'b0;
    fix          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        load    = q_valid;
      end
      ST_DIV:  ;
      ST_FIX:  fix = 1'b1;
      ST_OUT:  out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  assign mag   = q_data.value_sum[SumBits-1] ? SumBits'(-q_data.value_sum) : q_data.value_sum;
  assign trial = {rem_r[CountBits-1:0], quo_r[WorkBits-1]};
  assign take  = trial >= {1'b0, item_r.value_count};
  assign lim   = neg_r ? {1'b1, {(AvgBits-1){1'b0}}} : {1'b0, {(AvgBits-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= q_data;
      quo_r  <= {mag, {AvgFracBits{1'b0}}};
      rem_r  <= '0;
      step_r <= '0;
      neg_r  <= q_data.value_sum[SumBits-1];
    end else if (state_r == ST_DIV) begin
      rem_r  <= take ? trial - {1'b0, item_r.value_count} : trial;
      quo_r  <= {quo_r[WorkBits-2:0], take};
      step_r <= step_r + 1'b1;
    end else if (fix) begin
      if (item_r.no_values) begin
        avg_r <= '0;
      end else if ((|quo_r[WorkBits-1:AvgBits-1]) &&
                   !(neg_r && quo_r[WorkBits-1:AvgBits-1] == (WorkBits-AvgBits+1)'(1) &&
                     quo_r[AvgBits-2:0] == '0)) begin
        avg_r <= lim;
      end else begin
        avg_r <= neg_r ? AvgBits'(-quo_r[AvgBits-1:0]) : quo_r[AvgBits-1:0];
      end
    end
  end

  assign out_ch.row_count     = item_r.row_count;
  assign out_ch.value_count   = item_r.value_count;
  assign out_ch.value_sum     = item_r.value_sum;
  assign out_ch.value_avg     = avg_r;
  assign out_ch.value_min     = item_r.value_min;
  assign out_ch.value_max     = item_r.value_max;
  assign out_ch.no_values     = item_r.no_values;
  assign out_ch.new_partition = item_r.new_partition;

endmodule

>>> src/partitioned_running_aggregate.sv
// Running window aggregates over a stream sorted by partition key. The front stage folds each
// request into the running count, sum, minimum and maximum and can take a request every cycle
// while the queue has room; a two-entry queue then feeds the average unit, a restoring divider
// that retires one quotient bit per cycle, so each result goes through load, 80 divide steps,
// fix-up and output, and the unit takes a new request only after the last result is taken.
module partitioned_running_aggregate import pra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  pra_in_if.sink     in_ch,
  pra_out_if.source  out_ch
);

  logic     f_valid, f_ready, q_valid, q_ready;
  pra_acc_t f_data, q_data;

  pra_front u_front (
    .clk, .rst_n,
    .cfg_en(cfg_we), .cfg_partition_enable(cfg_wdata),
    .in_ch, .acc_valid(f_valid), .acc_ready(f_ready), .acc(f_data)
  );

  pra_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  pra_back u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data, .out_ch
  );

endmodule
